@@ hdl/height_palette_shader_unit_defines.svh @@
// ----------------------------------------------------------------------------
// height_palette_shader_unit_defines
// assertion macros used by the shader rtl
// ----------------------------------------------------------------------------
`ifndef HEIGHT_PALETTE_SHADER_UNIT_DEFINES_SVH
`define HEIGHT_PALETTE_SHADER_UNIT_DEFINES_SVH

// condition in the same cycle
`define HPS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition in the next cycle
`define HPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/hps_pkg.sv @@
// ----------------------------------------------------------------------------
// hps_pkg
// types and fixed field widths of the height palette shader
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int CHAN_W     = 8;
  localparam int RGB_W      = 3 * CHAN_W;
  localparam int SLOT_W     = 8;
  localparam int PSIZE_W    = 9;
  localparam int SHADE_W    = 8;
  localparam int SIDE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PALETTE_SIZE   = 2'd0,
    CFG_SHADING_ENABLE = 2'd1,
    CFG_SHADE_FACTOR   = 2'd2,
    CFG_IMAGE_SIDE     = 2'd3
  } cfg_index_t;

  typedef enum logic {
    CMD_PALETTE_WRITE = 1'b0,
    CMD_HEIGHT        = 1'b1
  } command_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // q8 scale, product of two 8-bit values shifted by 8 always fits 8 bits
  function automatic logic [CHAN_W-1:0] scale_channel(input logic [CHAN_W-1:0] c,
                                                      input logic [SHADE_W-1:0] f);
    logic [CHAN_W+SHADE_W-1:0] p;
    p = (CHAN_W+SHADE_W)'(c) * (CHAN_W+SHADE_W)'(f);
    return p[SHADE_W +: CHAN_W];
  endfunction

endpackage

@@ hdl/height_palette_shader_unit.sv @@
// ----------------------------------------------------------------------------
// height_palette_shader_unit
// maps raster height samples to palette colors with neighbor shading
// ----------------------------------------------------------------------------
// One input transaction per clock while the input does not stall, palette
// writes and height samples alike. Each height sample gives one pixel: the
// palette RAM and the line buffer are read and written at the accepting
// edge, the shade decision is registered in stage b and the channel
// scaling in the output registers. The three stages collapse bubbles, so
// input stalls only once all of them hold a pixel and the output is not
// taken. Palette entries and the line buffer hold no reset value: load the
// palette before use and keep image_side fixed within an image. The user
// must write configuration only while no pixel is in flight; the block
// itself does not enforce this.
`include "height_palette_shader_unit_defines.svh"

module height_palette_shader_unit #(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_SIDE      = 1025,
  parameter int HEIGHT_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [hps_pkg::SLOT_W-1:0]     palette_slot,
  input  logic [hps_pkg::RGB_W-1:0]      palette_rgb,
  input  logic [HEIGHT_BITS-1:0]         height,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hps_pkg::CHAN_W-1:0]     red,
  output logic [hps_pkg::CHAN_W-1:0]     green,
  output logic [hps_pkg::CHAN_W-1:0]     blue,
  output logic                           shaded,
  output logic                           end_of_image,
  input  logic                           cfg_we,
  input  logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
  localparam int COL_W   = $clog2(MAX_SIDE);
  localparam int PROD_W  = HEIGHT_BITS + hps_pkg::PSIZE_W;

  // configuration
  logic [hps_pkg::PSIZE_W-1:0] palette_size;
  logic                        shading_enable;
  logic [hps_pkg::SHADE_W-1:0] shade_factor;
  logic [hps_pkg::SIDE_W-1:0]  image_side;

  // raster position and left neighbor
  logic [hps_pkg::SIDE_W-1:0]  column_count;
  logic [hps_pkg::SIDE_W-1:0]  row_count;
  logic [HEIGHT_BITS-1:0]      left_height;

  // storage
  logic [hps_pkg::RGB_W-1:0]   palette_mem [PALETTE_DEPTH];
  logic [HEIGHT_BITS-1:0]      row_mem [MAX_SIDE];

  // stage a: memory read data and neighbor context
  logic                        a_valid;
  hps_pkg::rgb_t               a_rgb;
  logic [HEIGHT_BITS-1:0]      a_up;
  logic [HEIGHT_BITS-1:0]      a_left;
  logic [HEIGHT_BITS-1:0]      a_h;
  logic                        a_has_up;
  logic                        a_has_left;
  logic                        a_black;
  logic                        a_eoi;
  logic                        a_shade;

  // stage b: chosen color and shade decision
  logic                        b_valid;
  hps_pkg::rgb_t               b_rgb;
  logic                        b_shaded;
  logic                        b_eoi;

  logic                        o_ready;
  logic                        b_ready;
  logic                        pixel_accept;
  logic                        palette_accept;

  logic [31:0]                 side_eff;
  logic [hps_pkg::PSIZE_W-1:0] n_eff;
  logic [hps_pkg::PSIZE_W-1:0] n_minus_1;
  logic [PROD_W-1:0]           prod;
  logic [hps_pkg::PSIZE_W-1:0] slot_q;
  logic [hps_pkg::PSIZE_W-1:0] pal_idx;
  logic [PAL_AW-1:0]           pal_addr;
  logic [PAL_AW-1:0]           wr_addr;
  logic                        slot_ok;
  logic [COL_W-1:0]            col;
  logic                        col_wrap;
  logic                        row_wrap;
  logic [HEIGHT_BITS:0]        nb_sum;
  logic [HEIGHT_BITS:0]        h_dbl;

  // handshake, bubbles collapse stage by stage
  assign o_ready        = !out_valid || out_ready;
  assign b_ready        = !b_valid || o_ready;
  assign in_ready       = !a_valid || b_ready;
  assign pixel_accept   = in_valid && in_ready && (command == hps_pkg::CMD_HEIGHT);
  assign palette_accept = in_valid && in_ready && (command == hps_pkg::CMD_PALETTE_WRITE);

  // effective side and palette size
  always_comb begin
    priority if (image_side == '0) begin
      side_eff = 32'd1;
    end else if (32'(image_side) > MAX_SIDE) begin
      side_eff = 32'(MAX_SIDE);
    end else begin
      side_eff = 32'(image_side);
    end
  end

  assign n_eff     = (32'(palette_size) > PALETTE_DEPTH) ? hps_pkg::PSIZE_W'(PALETTE_DEPTH)
                                                         : palette_size;
  assign n_minus_1 = n_eff - 1'b1;
  assign prod      = PROD_W'(height) * PROD_W'(n_minus_1);
  assign slot_q    = prod[HEIGHT_BITS +: hps_pkg::PSIZE_W];
  assign pal_idx   = (slot_q > n_minus_1) ? n_minus_1 : slot_q;
  assign pal_addr  = PAL_AW'(pal_idx);
  assign wr_addr   = PAL_AW'(palette_slot);
  assign slot_ok   = 32'(palette_slot) < PALETTE_DEPTH;

  assign col      = (32'(column_count) < MAX_SIDE) ? COL_W'(column_count)
                                                   : COL_W'(MAX_SIDE - 1);
  assign col_wrap = (32'(column_count) + 32'd1) >= side_eff;
  assign row_wrap = (32'(row_count) + 32'd1) >= side_eff;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size   <= hps_pkg::PSIZE_W'(1);
      shading_enable <= 1'b0;
      shade_factor   <= hps_pkg::SHADE_W'(128);
      image_side     <= hps_pkg::SIDE_W'(1025);
    end else if (cfg_we) begin
      unique case (hps_pkg::cfg_index_t'(cfg_index))
        hps_pkg::CFG_PALETTE_SIZE:   palette_size   <= cfg_data[hps_pkg::PSIZE_W-1:0];
        hps_pkg::CFG_SHADING_ENABLE: shading_enable <= cfg_data[0];
        hps_pkg::CFG_SHADE_FACTOR:   shade_factor   <= cfg_data[hps_pkg::SHADE_W-1:0];
        hps_pkg::CFG_IMAGE_SIDE:     image_side     <= cfg_data[hps_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // palette ram, read at the accepting edge so writes and reads keep order
  always_ff @(posedge clk) begin
    if (palette_accept && slot_ok) begin
      palette_mem[wr_addr] <= palette_rgb;
    end
    if (pixel_accept) begin
      a_rgb <= palette_mem[pal_addr];
    end
  end

  // line buffer, old value read while the new sample replaces it
  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      a_up         <= row_mem[col];
      row_mem[col] <= height;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= pixel_accept;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (o_ready) begin
        out_valid <= b_valid;
      end
      if (pixel_accept) begin
        if (col_wrap) begin
          column_count <= '0;
          row_count    <= row_wrap ? '0 : row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

  // shade decision from the neighbors present
  always_comb begin
    nb_sum  = {1'b0, a_up} + {1'b0, a_left};
    h_dbl   = {a_h, 1'b0};
    a_shade = 1'b0;
    if (shading_enable) begin
      priority if (a_has_up && a_has_left) begin
        a_shade = h_dbl < nb_sum;
      end else if (a_has_up) begin
        a_shade = a_h < a_up;
      end else if (a_has_left) begin
        a_shade = a_h < a_left;
      end else begin
        a_shade = 1'b0;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      left_height <= height;
      a_h         <= height;
      a_left      <= left_height;
      a_has_up    <= row_count != '0;
      a_has_left  <= column_count != '0;
      a_black     <= n_eff == '0;
      a_eoi       <= col_wrap && row_wrap;
    end
    if (b_ready && a_valid) begin
      b_rgb    <= a_black ? '0 : a_rgb;
      b_shaded <= a_shade;
      b_eoi    <= a_eoi;
    end
    if (o_ready && b_valid) begin
      red          <= b_shaded ? hps_pkg::scale_channel(b_rgb.red, shade_factor) : b_rgb.red;
      green        <= b_shaded ? hps_pkg::scale_channel(b_rgb.green, shade_factor)
                               : b_rgb.green;
      blue         <= b_shaded ? hps_pkg::scale_channel(b_rgb.blue, shade_factor) : b_rgb.blue;
      shaded       <= b_shaded;
      end_of_image <= b_eoi;
    end
  end

  `HPS_ASSERT_NEXT(a_palette_no_pixel, palette_accept, !a_valid,
                   "palette write entered the pixel pipeline")
  `HPS_ASSERT_NEXT(a_eoi_resets_raster, pixel_accept && col_wrap && row_wrap,
                   column_count == '0 && row_count == '0,
                   "raster counters not cleared after last pixel")
  `HPS_ASSERT_NOW(a_stall_only_when_full, !in_ready,
                  a_valid && b_valid && out_valid && !out_ready,
                  "input stalled with room in the pipeline")

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for height_palette_shader_unit
// ----------------------------------------------------------------------------
// Loads the whole palette, then streams complete square images of height
// samples under a series of register settings: small directed images for the
// neighbor rules and register extremes, random phases with palette updates
// mixed into the pixel stream, and a closing partial image at the widest side.
// Every pixel is predicted at acceptance and compared field by field at the
// output, with random idle cycles on both handshakes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAL_DEPTH      = 256;
  localparam int LINE_LEN       = 1025;
  localparam int HBITS          = 16;
  localparam int HEIGHT_MAX     = (1 << HBITS) - 1;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TARGET  = 150;
  localparam int WIDE_SIDE      = 2047;

  typedef struct packed {
    hps_pkg::command_t          cmd;
    logic [hps_pkg::SLOT_W-1:0] slot;
    logic [hps_pkg::RGB_W-1:0]  rgb;
    logic [HBITS-1:0]           h;
  } shader_txn_t;

  typedef struct packed {
    logic [hps_pkg::CHAN_W-1:0] red;
    logic [hps_pkg::CHAN_W-1:0] green;
    logic [hps_pkg::CHAN_W-1:0] blue;
    logic                       shaded;
    logic                       eoi;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           command = hps_pkg::CMD_PALETTE_WRITE;
  logic [hps_pkg::SLOT_W-1:0]     palette_slot = '0;
  logic [hps_pkg::RGB_W-1:0]      palette_rgb = '0;
  logic [HBITS-1:0]               height = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [hps_pkg::CHAN_W-1:0]     red;
  logic [hps_pkg::CHAN_W-1:0]     green;
  logic [hps_pkg::CHAN_W-1:0]     blue;
  logic                           shaded;
  logic                           end_of_image;
  logic                           cfg_we = 1'b0;
  logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index = hps_pkg::CFG_PALETTE_SIZE;
  logic [hps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  height_palette_shader_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .palette_slot (palette_slot),
    .palette_rgb  (palette_rgb),
    .height       (height),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .shaded       (shaded),
    .end_of_image (end_of_image),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shader state as the bench sees it
  logic [hps_pkg::RGB_W-1:0]   pal_mem [PAL_DEPTH];
  logic [HBITS-1:0]            line_buf [LINE_LEN];
  logic [HBITS-1:0]            prev_height = '0;
  int                          col_pos = 0;
  int                          row_pos = 0;
  logic [hps_pkg::PSIZE_W-1:0] reg_psize = 9'd1;
  logic                        reg_shade_on = 1'b0;
  logic [hps_pkg::SHADE_W-1:0] reg_factor = 8'd128;
  logic [hps_pkg::SIDE_W-1:0]  reg_side = 11'd1025;

  shader_txn_t pending_cmds[$];
  pixel_t      expected_pixels[$];
  shader_txn_t cur_txn;
  logic        in_fire = 1'b0;

  int fail_count = 0;
  int pixel_count = 0;
  int shaded_count = 0;
  int image_count = 0;
  int pal_write_count = 0;
  int setting_count = 0;
  int cycle_cnt = 0;
  int quiet_cycles = 0;

  // one stretch of the run with no idling on either side
  wire calm = (cycle_cnt >= 1200) && (cycle_cnt < 1800);

  function automatic int side_in_use();
    if (reg_side == 0) return 1;
    if (reg_side > LINE_LEN) return LINE_LEN;
    return int'(reg_side);
  endfunction

  function automatic logic [hps_pkg::CHAN_W-1:0] dim(input logic [hps_pkg::CHAN_W-1:0] c);
    return hps_pkg::CHAN_W'((int'(c) * int'(reg_factor)) >> 8);
  endfunction

  // updates the bench state for one transaction; returns 1 when a pixel results
  function automatic bit render_pixel(input shader_txn_t t, output pixel_t px);
    int                        n;
    int                        slot_idx;
    int                        side;
    int                        hv;
    int                        up_h;
    int                        left_h;
    logic [hps_pkg::RGB_W-1:0] color;
    bit                        sh;

    px = '0;
    if (t.cmd == hps_pkg::CMD_PALETTE_WRITE) begin
      pal_mem[t.slot] = t.rgb;
      pal_write_count++;
      return 1'b0;
    end
    side = side_in_use();
    n = (reg_psize > PAL_DEPTH) ? PAL_DEPTH : int'(reg_psize);
    hv = int'(t.h);
    color = '0;
    if (n != 0) begin
      slot_idx = (hv * (n - 1)) >> HBITS;
      if (slot_idx > n - 1) slot_idx = n - 1;
      color = pal_mem[slot_idx];
    end
    sh = 1'b0;
    if (reg_shade_on) begin
      left_h = int'(prev_height);
      if (row_pos > 0) begin
        up_h = int'(line_buf[col_pos]);
        if (col_pos > 0) sh = (2 * hv) < (up_h + left_h);
        else sh = hv < up_h;
      end else if (col_pos > 0) begin
        sh = hv < left_h;
      end
    end
    px.red    = sh ? dim(color[23:16]) : color[23:16];
    px.green  = sh ? dim(color[15:8]) : color[15:8];
    px.blue   = sh ? dim(color[7:0]) : color[7:0];
    px.shaded = sh;
    line_buf[col_pos] = t.h;
    prev_height = t.h;
    if (col_pos + 1 >= side) begin
      col_pos = 0;
      if (row_pos + 1 >= side) begin
        row_pos = 0;
        px.eoi = 1'b1;
        image_count++;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    pixel_count++;
    if (sh) shaded_count++;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // input side: predict every accepted transaction
  always @(posedge clk) begin : accept_side
    pixel_t px;
    in_fire = 1'b0;
    if (!rst && in_valid && in_ready) begin
      in_fire = 1'b1;
      if (render_pixel(cur_txn, px)) expected_pixels.push_back(px);
    end
  end

  // output side: compare each pixel with the oldest prediction, plus watchdog
  always @(posedge clk) begin : out_monitor
    pixel_t want;
    if (!rst) begin
      cycle_cnt++;
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel with no prediction pending: rgb %h%h%h", red, green, blue);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", want.red, red);
          check_field("green", want.green, green);
          check_field("blue", want.blue, blue);
          check_field("shaded", want.shaded, shaded);
          check_field("end_of_image", want.eoi, end_of_image);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles, %0d pixels outstanding",
                   quiet_cycles, expected_pixels.size());
          $display("FAIL height_palette_shader_unit");
          $finish;
        end
      end
    end
  end

  // driver: new transaction only after the previous one was taken
  always @(negedge clk) begin : feeder
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
          cur_txn = pending_cmds.pop_front();
          in_valid     <= 1'b1;
          command      <= cur_txn.cmd;
          palette_slot <= cur_txn.slot;
          palette_rgb  <= cur_txn.rgb;
          height       <= cur_txn.h;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 26);
    end
  end

  function automatic void push_palette(input int slot, input int rgb);
    shader_txn_t t;
    t.cmd  = hps_pkg::CMD_PALETTE_WRITE;
    t.slot = hps_pkg::SLOT_W'(slot);
    t.rgb  = hps_pkg::RGB_W'(rgb);
    t.h    = HBITS'($urandom);
    pending_cmds.push_back(t);
  endfunction

  function automatic void push_height(input int h);
    shader_txn_t t;
    t.cmd  = hps_pkg::CMD_HEIGHT;
    t.slot = hps_pkg::SLOT_W'($urandom);
    t.rgb  = hps_pkg::RGB_W'($urandom);
    t.h    = HBITS'(h);
    pending_cmds.push_back(t);
  endfunction

  function automatic int next_height(input int mode, input int prev);
    int v;
    case (mode)
      0: v = int'(HBITS'($urandom));
      1: begin
        // gentle slope, shading follows the local terrain
        v = prev + $urandom_range(0, 4000) - 2000;
        if (v < 0) v = 0;
        if (v > HEIGHT_MAX) v = HEIGHT_MAX;
      end
      default: begin
        case ($urandom_range(4))
          0: v = 0;
          1: v = 1;
          2: v = HEIGHT_MAX - 1;
          3: v = HEIGHT_MAX;
          default: v = 1 << (HBITS - 1);
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic write_reg(input hps_pkg::cfg_index_t idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= hps_pkg::CFG_DATA_W'(val);
    case (idx)
      hps_pkg::CFG_PALETTE_SIZE:   reg_psize    = hps_pkg::PSIZE_W'(val);
      hps_pkg::CFG_SHADING_ENABLE: reg_shade_on = val[0];
      hps_pkg::CFG_SHADE_FACTOR:   reg_factor   = hps_pkg::SHADE_W'(val);
      hps_pkg::CFG_IMAGE_SIDE:     reg_side     = hps_pkg::SIDE_W'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int psize, input int shade_on, input int factor,
                           input int side);
    write_reg(hps_pkg::CFG_PALETTE_SIZE, psize);
    write_reg(hps_pkg::CFG_SHADING_ENABLE, shade_on);
    write_reg(hps_pkg::CFG_SHADE_FACTOR, factor);
    write_reg(hps_pkg::CFG_IMAGE_SIDE, side);
    setting_count++;
  endtask

  // block idle: everything sent, every pixel back, pipeline drained
  // checked at the rising edge, where the driver's last update has settled
  task automatic settle();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int random_items;
    int side;
    int imgs;
    int mode;
    int hv;
    int psize;
    int factor;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full palette first, so no pixel ever reads an empty entry
    configure(256, 1, 230, 3);
    for (int s = 0; s < PAL_DEPTH; s++) push_palette(s, $urandom);

    // directed 3x3 image: corner, edge neighbors, both neighbors, tie
    push_palette(0, 24'hFFFFFF);
    push_palette(255, 24'h000000);
    push_palette(254, 24'h80FF01);
    push_height(40000);
    push_height(HEIGHT_MAX);
    push_height(0);
    push_height(30001);
    push_height(47768);           // 2h equals up + left, not shaded
    push_height(1);
    push_height(HEIGHT_MAX);
    push_height(20000);
    push_height(HEIGHT_MAX - 1);
    settle();

    // zero palette size and zero side: black single-pixel images
    configure(0, 1, 0, 0);
    push_height(0);
    push_height(HEIGHT_MAX);
    push_height(1);
    settle();

    // zero palette on a 2x2 image still reports shading
    configure(0, 1, 255, 2);
    push_height(HEIGHT_MAX);
    push_height(HEIGHT_MAX);
    push_height(0);
    push_height(100);
    settle();

    // oversized palette size, full shade factor
    configure(511, 1, 255, 2);
    push_height(HEIGHT_MAX);
    push_height(1000);
    push_height(0);
    push_height(HEIGHT_MAX);
    settle();

    random_items = 0;
    while (random_items < RANDOM_TARGET) begin
      case ($urandom_range(7))
        0: psize = 0;
        1: psize = 1;
        2: psize = 2;
        3: psize = 256;
        4: psize = $urandom_range(257, 511);
        default: psize = $urandom_range(1, 256);
      endcase
      case ($urandom_range(5))
        0: factor = 0;
        1: factor = 255;
        2: factor = 26;
        3: factor = 230;
        default: factor = $urandom_range(0, 255);
      endcase
      case ($urandom_range(7))
        0: side = 0;
        1: side = 1;
        2: side = 2;
        3: side = 3;
        default: side = $urandom_range(3, 10);
      endcase
      configure(psize, ($urandom_range(3) != 0), factor, side);
      side = side_in_use();
      imgs = $urandom_range(1, 2);
      mode = $urandom_range(2);
      hv = $urandom_range(0, HEIGHT_MAX);
      for (int p = 0; p < imgs * side * side; p++) begin
        if ($urandom_range(99) < 12) begin
          push_palette($urandom, $urandom);
          random_items++;
        end
        hv = next_height(mode, hv);
        push_height(hv);
        random_items++;
      end
      settle();
    end

    // widest side: side above the maximum is clamped, one full row plus a bit
    configure($urandom_range(2, 256), 1, $urandom_range(26, 230), WIDE_SIDE);
    hv = $urandom_range(0, HEIGHT_MAX);
    for (int p = 0; p < LINE_LEN + 24; p++) begin
      if ($urandom_range(99) < 2) push_palette($urandom, $urandom);
      hv = next_height(($urandom_range(9) == 0) ? 0 : 1, hv);
      push_height(hv);
    end

    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pixels, %0d complete images, %0d palette writes, %0d settings",
             pixel_count, image_count, pal_write_count, setting_count);
    $display("%0d pixels shaded, %0d mismatches", shaded_count, fail_count);
    if (fail_count == 0) begin
      $display("PASS height_palette_shader_unit");
    end else begin
      $display("FAIL height_palette_shader_unit");
    end
    $finish;
  end

endmodule
